// ===== rtl/core/ssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Shared word types, segment codes and unit mode codes.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = $clog2(NUM_DIGITS);
  localparam int SEG_W      = 8;
  localparam int CNT_W      = $clog2(SEG_W + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] MODE_VOLT  = 2'd0;
  localparam logic [1:0] MODE_CURR  = 2'd1;
  localparam logic [1:0] MODE_POWER = 2'd2;

  localparam logic [SEG_W-1:0] SEG_DP = 8'h80;
  localparam logic [SEG_W-1:0] SEG_V  = 8'h3E;
  localparam logic [SEG_W-1:0] SEG_A  = 8'h77;
  localparam logic [SEG_W-1:0] SEG_P  = 8'h73;

  localparam int DP_VOLT  = 1;
  localparam int DP_POWER = 0;

  localparam logic [9:0]  SHOWN_MAX = 10'd999;
  localparam logic [16:0] RECIP10   = 17'd104858;
  localparam logic [17:0] RECIP100  = 18'd167773;
  localparam logic [5:0]  RECIP100S = 6'd41;
  localparam logic [7:0]  RECIP10S  = 8'd205;

  typedef struct packed {
    logic        cmd;
    logic [16:0] value_hundredths;
    logic [1:0]  unit_mode;
  } in_word_t;

  typedef struct packed {
    logic       serial_bit;
    logic       is_latch;
    logic [3:0] digit_enables_n;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic                                is_tick;
    logic [NUM_DIGITS-1:0][SEG_W-1:0]    bytes;
  } q_entry_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/ssd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver front end
// Accepts words, scales load values and turns them into four segment bytes.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ssd_pkg::in_word_t item,
  output logic              q_push,
  input  logic              q_full,
  output ssd_pkg::q_entry_t q_entry
);

  logic              v1;
  ssd_pkg::in_word_t c1;
  logic              v2;
  logic              cmd2;
  logic [1:0]        mode2;
  logic              zero2;
  logic [9:0]        shown2;

  logic        advance;
  logic        load_s1;
  logic [33:0] prod10;
  logic [34:0] prod100;
  logic [16:0] scaled;
  logic [9:0]  shown;
  logic        drop;

  logic [15:0] hp;
  logic [17:0] tp;
  logic [3:0]  hund;
  logic [6:0]  tens_all;
  logic [6:0]  tens_w;
  logic [9:0]  ones_w;

  assign advance = !v2 || !q_full;
  assign full    = v1 && !advance;
  assign load_s1 = !v1 || advance;

  assign prod10  = 34'(c1.value_hundredths) * 34'(ssd_pkg::RECIP10);
  assign prod100 = 35'(c1.value_hundredths) * 35'(ssd_pkg::RECIP100);

  always_comb begin
    case (c1.unit_mode)
      ssd_pkg::MODE_VOLT: scaled = {3'b000, prod10[33:20]};
      ssd_pkg::MODE_CURR: scaled = {6'b000000, prod100[34:24]};
      default:            scaled = c1.value_hundredths;
    endcase
    shown = (scaled > 17'(ssd_pkg::SHOWN_MAX)) ? ssd_pkg::SHOWN_MAX : scaled[9:0];
    drop  = (c1.cmd == ssd_pkg::CMD_LOAD) && (c1.unit_mode > ssd_pkg::MODE_POWER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load_s1) begin
        v1 <= push;
      end
      if (advance) begin
        v2 <= v1 && !drop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1 && push) begin
      c1 <= item;
    end
    if (advance) begin
      cmd2   <= c1.cmd;
      mode2  <= c1.unit_mode;
      zero2  <= (c1.value_hundredths == 17'd0);
      shown2 <= shown;
    end
  end

  assign hp       = 16'(shown2) * 16'(ssd_pkg::RECIP100S);
  assign tp       = 18'(shown2) * 18'(ssd_pkg::RECIP10S);
  assign hund     = hp[15:12];
  assign tens_all = tp[17:11];
  assign tens_w   = tens_all - 7'(hund) * 7'd10;
  assign ones_w   = shown2 - 10'(tens_all) * 10'd10;

  always_comb begin
    q_entry.is_tick = (cmd2 == ssd_pkg::CMD_TICK);
    if (zero2) begin
      for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
        q_entry.bytes[i] = ssd_pkg::seg_of(4'd0);
      end
    end else begin
      q_entry.bytes[0] = ssd_pkg::seg_of(hund);
      q_entry.bytes[1] = ssd_pkg::seg_of(tens_w[3:0]);
      q_entry.bytes[2] = ssd_pkg::seg_of(ones_w[3:0]);
      case (mode2)
        ssd_pkg::MODE_VOLT: q_entry.bytes[3] = ssd_pkg::SEG_V;
        ssd_pkg::MODE_CURR: q_entry.bytes[3] = ssd_pkg::SEG_A;
        default:            q_entry.bytes[3] = ssd_pkg::SEG_P;
      endcase
    end
    case (mode2)
      ssd_pkg::MODE_VOLT: q_entry.bytes[ssd_pkg::DP_VOLT] =
                            q_entry.bytes[ssd_pkg::DP_VOLT] | ssd_pkg::SEG_DP;
      ssd_pkg::MODE_POWER: q_entry.bytes[ssd_pkg::DP_POWER] =
                             q_entry.bytes[ssd_pkg::DP_POWER] | ssd_pkg::SEG_DP;
      default: ;
    endcase
  end

  assign q_push = v2 && !q_full;

endmodule

// ===== rtl/core/ssd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver queue
// Small first-in first-out queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module ssd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  output logic              full,
  input  ssd_pkg::q_entry_t wr_data,
  output logic              valid,
  input  logic              rd_en,
  output ssd_pkg::q_entry_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssd_pkg::q_entry_t mem [DEPTH];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/ssd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver back end
// Holds the digit store and scan state and serializes refresh ticks.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  ssd_pkg::q_entry_t  q_head,
  output logic               empty,
  input  logic               pop,
  output ssd_pkg::out_word_t result
);

  localparam int ND = ssd_pkg::NUM_DIGITS;
  localparam int PW = ssd_pkg::POS_W;
  localparam int CW = ssd_pkg::CNT_W;

  logic [ND-1:0][ssd_pkg::SEG_W-1:0] store;
  logic [PW-1:0]                     pos;
  logic [ND-1:0]                     en_n;
  logic                              active;
  logic [CW-1:0]                     cnt;
  logic [ssd_pkg::SEG_W-1:0]         sh;
  logic                              out_valid;

  logic          emit;
  logic          emit_latch;
  logic          head_load;
  logic          start;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] rd_pos;
  logic [ND-1:0] latch_en;

  assign emit       = active && (!out_valid || pop);
  assign emit_latch = emit && (cnt == CW'(ssd_pkg::SEG_W));
  assign head_load  = q_valid && !q_head.is_tick;
  assign start      = q_valid && q_head.is_tick && (!active || emit_latch);
  assign q_pop      = head_load || start;
  assign pos_inc    = (pos == PW'(ND - 1)) ? '0 : pos + 1'b1;
  assign rd_pos     = active ? pos_inc : pos;
  assign latch_en   = ~({{(ND - 1){1'b0}}, 1'b1} << pos);
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      store     <= '0;
      pos       <= '0;
      en_n      <= '1;
      active    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (head_load) begin
        store <= q_head.bytes;
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (emit_latch) begin
          active <= 1'b0;
          en_n   <= latch_en;
          pos    <= pos_inc;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (emit_latch) begin
        result.serial_bit      <= 1'b0;
        result.is_latch        <= 1'b1;
        result.digit_enables_n <= latch_en;
        result.last            <= 1'b1;
      end else begin
        result.serial_bit      <= sh[ssd_pkg::SEG_W-1];
        result.is_latch        <= 1'b0;
        result.digit_enables_n <= en_n;
        result.last            <= 1'b0;
        sh                     <= sh << 1;
      end
    end
    if (start) begin
      sh <= store[rd_pos];
    end
  end

  a_latch_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.is_latch |-> $countones(result.digit_enables_n) == ND - 1)
    else $error("latch word does not enable exactly one digit");

  a_latch_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.is_latch == result.last)
    else $error("last flag differs from latch flag");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active |-> cnt <= CW'(ssd_pkg::SEG_W))
    else $error("bit counter out of range");

  a_latch_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit_latch && !start |=> !active)
    else $error("serializer still active after latch word");

endmodule

// ===== rtl/core/seven_segment_mux_display_driver.sv =====
`timescale 1ns / 1ps
// A refresh tick produces nine result words, eight segment bits MSB first and
// then one latch word, at one word per cycle when the result side keeps
// popping; that rate is set by the bit serializer in the back end. A load
// produces no words and only writes the digit store. Input words are taken
// every cycle while the queue between front and back has room; the front end
// registers each word, scales it and registers the result, then splits digits.
// ----------------------------------------------------------------------------
// Seven-segment display driver top level
// Front end, decoded-word queue and serializing back end.
// ----------------------------------------------------------------------------
module seven_segment_mux_display_driver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ssd_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output ssd_pkg::out_word_t result
);

  logic              f_push;
  logic              f_full;
  ssd_pkg::q_entry_t f_entry;
  logic              q_valid;
  logic              q_pop;
  ssd_pkg::q_entry_t q_head;

  ssd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_push  (f_push),
    .q_full  (f_full),
    .q_entry (f_entry)
  );

  ssd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .full    (f_full),
    .wr_data (f_entry),
    .valid   (q_valid),
    .rd_en   (q_pop),
    .rd_data (q_head)
  );

  ssd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== sim/seven_segment_mux_display_driver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver testbench
// Loads readings in every unit mode and sends refresh ticks. A local display
// model predicts the shifted segment bits and latch words of each tick. Both
// handshakes stall at random except in the final steady refresh phase.
// ----------------------------------------------------------------------------
module seven_segment_mux_display_driver_tb;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  ssd_pkg::in_word_t  item;
  logic               empty;
  logic               pop;
  ssd_pkg::out_word_t result;

  logic [7:0]         shown_segs [ssd_pkg::NUM_DIGITS];
  logic [1:0]         scan_pos;
  logic [3:0]         enables_n;
  ssd_pkg::out_word_t expected_words [$];
  int                 failures = 0;
  int                 stall_left = 0;
  bit                 calm = 1'b0;

  seven_segment_mux_display_driver dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ssd_pkg::in_word_t make_word(logic c, logic [16:0] v, logic [1:0] m);
    ssd_pkg::in_word_t w;
    w.cmd = c;
    w.value_hundredths = v;
    w.unit_mode = m;
    return w;
  endfunction

  task automatic load_reading(ssd_pkg::in_word_t w);
    int          dp_pos;
    logic [16:0] scaled;
    logic [9:0]  shown;
    logic [7:0]  unit_seg;
    int          digit [3];
    if (w.unit_mode == MODE_UNDEF) begin
      return;
    end
    dp_pos = (w.unit_mode == ssd_pkg::MODE_VOLT) ? 1 :
             (w.unit_mode == ssd_pkg::MODE_POWER) ? 0 : -1;
    if (w.value_hundredths == 17'd0) begin
      for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
        shown_segs[i] = DIGIT_SEG[0] | ((i == dp_pos) ? ssd_pkg::SEG_DP : 8'h00);
      end
      return;
    end
    case (w.unit_mode)
      ssd_pkg::MODE_VOLT: begin
        scaled = w.value_hundredths / 17'd10;
        unit_seg = ssd_pkg::SEG_V;
      end
      ssd_pkg::MODE_CURR: begin
        scaled = w.value_hundredths / 17'd100;
        unit_seg = ssd_pkg::SEG_A;
      end
      default: begin
        scaled = w.value_hundredths;
        unit_seg = ssd_pkg::SEG_P;
      end
    endcase
    shown = (scaled > 17'd999) ? 10'd999 : scaled[9:0];
    digit[0] = int'(shown / 10'd100);
    digit[1] = int'((shown / 10'd10) % 10'd10);
    digit[2] = int'(shown % 10'd10);
    for (int i = 0; i < 3; i++) begin
      shown_segs[i] = DIGIT_SEG[digit[i]] | ((i == dp_pos) ? ssd_pkg::SEG_DP : 8'h00);
    end
    shown_segs[ssd_pkg::NUM_DIGITS-1] = unit_seg;
  endtask

  task automatic predict_word(ssd_pkg::in_word_t w);
    ssd_pkg::out_word_t r;
    logic [7:0]         seg_bits;
    if (w.cmd == ssd_pkg::CMD_LOAD) begin
      load_reading(w);
      return;
    end
    seg_bits = shown_segs[scan_pos];
    for (int k = 7; k >= 0; k--) begin
      r.serial_bit = seg_bits[k];
      r.is_latch = 1'b0;
      r.digit_enables_n = enables_n;
      r.last = 1'b0;
      expected_words.push_back(r);
    end
    enables_n = ~(4'b0001 << scan_pos);
    r.serial_bit = 1'b0;
    r.is_latch = 1'b1;
    r.digit_enables_n = enables_n;
    r.last = 1'b1;
    expected_words.push_back(r);
    scan_pos = scan_pos + 2'd1;
  endtask

  task automatic send_word(ssd_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    predict_word(w);
  endtask

  function automatic logic [16:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'($urandom_range(1, 99));
      2:       return 17'($urandom_range(100, 9999));
      3:       return 17'($urandom_range(65536, 99999));
      default: return 17'($urandom_range(0, 99999));
    endcase
  endfunction

  function automatic logic [1:0] random_mode();
    return ($urandom_range(0, 9) == 0) ? MODE_UNDEF : 2'($urandom_range(0, 2));
  endfunction

  task automatic send_tick();
    send_word(make_word(ssd_pkg::CMD_TICK, random_value(), 2'($urandom_range(0, 3))));
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_tick();
  endtask

  task automatic check_word(ssd_pkg::out_word_t got);
    ssd_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      failures++;
      return;
    end
    want = expected_words.pop_front();
    if (got.serial_bit !== want.serial_bit) begin
      $display("%0t: serial_bit expected %b actual %b", $time, want.serial_bit,
               got.serial_bit);
      failures++;
    end
    if (got.is_latch !== want.is_latch) begin
      $display("%0t: is_latch expected %b actual %b", $time, want.is_latch, got.is_latch);
      failures++;
    end
    if (got.digit_enables_n !== want.digit_enables_n) begin
      $display("%0t: digit_enables_n expected %b actual %b", $time,
               want.digit_enables_n, got.digit_enables_n);
      failures++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %b actual %b", $time, want.last, got.last);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        check_word(result);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_blank_scan();
    send_ticks(1);
  endtask

  task automatic test_zero_readings();
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd0, ssd_pkg::MODE_VOLT));
    send_ticks(4);
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd0, ssd_pkg::MODE_POWER));
    send_ticks(4);
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd0, ssd_pkg::MODE_CURR));
    send_ticks(1);
  endtask

  task automatic test_range_limits();
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd99999, ssd_pkg::MODE_POWER));
    send_ticks(4);
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd5, ssd_pkg::MODE_VOLT));
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd99999, ssd_pkg::MODE_CURR));
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'h1FFFF, MODE_UNDEF));
    send_ticks(4);
    send_word(make_word(ssd_pkg::CMD_LOAD, 17'd99, ssd_pkg::MODE_CURR));
    send_ticks(1);
  endtask

  task automatic test_random_readings();
    int sent;
    sent = 0;
    while (sent < 120) begin
      if ($urandom_range(0, 7) == 0) begin
        send_tick();
        sent++;
      end else begin
        send_word(make_word(ssd_pkg::CMD_LOAD, random_value(), random_mode()));
        sent++;
        for (int n = $urandom_range(1, 6); n > 0; n--) begin
          send_tick();
          sent++;
        end
      end
    end
  endtask

  task automatic test_steady_refresh();
    calm = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 8 == 0) begin
        send_word(make_word(ssd_pkg::CMD_LOAD, random_value(), 2'($urandom_range(0, 2))));
      end else begin
        send_tick();
      end
    end
    push <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
      shown_segs[i] = 8'h00;
    end
    scan_pos = 2'd0;
    enables_n = 4'hF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_blank_scan();
    test_zero_readings();
    test_range_limits();
    test_random_readings();
    test_steady_refresh();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
